FILE: src/wpl_pkg.sv
// Shared widths, constants and types of the weighted path length block.
`timescale 1ns / 1ps
package wpl_pkg;

   localparam int COORD_W     = 24;
   localparam int COEF_W      = 24;
   localparam int CSR_COUNT   = 6;
   localparam int CSR_IDX_W   = 3;
   localparam int MAG_W       = 24;
   localparam int SQ_W        = 48;
   localparam int TERM_W      = 49;
   localparam int SUM_W       = 52;
   localparam int RAD_W       = 48;
   localparam int ROOT_W      = 24;
   localparam int TOTAL_W     = 32;
   localparam int COEF_FRAC   = 16;

   // pipeline depth of a lane (load to term) and of the merging tree
   localparam int LANE_DEPTH  = 5;
   localparam int MERGE_DEPTH = 2;

   localparam logic [MAG_W-1:0]  TWO_PI_Q13 = 24'd51472;
   localparam logic [MAG_W-1:0]  PI_Q13     = 24'd25736;
   localparam logic [TERM_W-1:0] TERM_CAP   = 49'h1_0000_0000_0000;
   localparam logic [COEF_W-1:0] COEF_ONE   = 24'h01_0000;

   typedef logic [TERM_W-1:0] term_type;

   // radicand of the root unit: sat marks a sum at or above 2^48
   typedef struct packed {
      logic             sat;
      logic [RAD_W-1:0] value;
   } radicand_type;

endpackage

FILE: src/wpl_lane.sv
// One dimension lane: difference, angle wrap, square and coefficient scaling.
`timescale 1ns / 1ps
module wpl_lane
   import wpl_pkg::*;
#(
   parameter bit IS_ANGLE = 1'b0
) (
   input  logic                      clock,
   input  logic                      load,
   input  logic signed [COORD_W-1:0] coord,
   input  logic        [COEF_W-1:0]  coef,
   output term_type                  term
);

   localparam int WIDE_W = SQ_W + (MAG_W - COEF_FRAC) + 1;

   logic signed [COORD_W-1:0] cur_ff;
   logic signed [COORD_W-1:0] prev_ff;
   logic signed [COORD_W:0]   diff;
   logic        [COORD_W:0]   mag_abs;
   logic        [MAG_W-1:0]   mag_in;
   logic        [MAG_W-1:0]   mag_ff;
   logic        [SQ_W-1:0]    sq_ff;
   logic        [SQ_W-1:0]    plo_ff;
   logic        [MAG_W-1:0]   sqhi_ff;
   logic        [SQ_W-1:0]    phi_ff;
   logic        [WIDE_W-1:0]  wide;
   term_type                  term_in;
   term_type                  term_ff;

   always_comb begin
      diff    = (COORD_W+1)'(cur_ff) - (COORD_W+1)'(prev_ff);
      mag_abs = diff[COORD_W] ? (COORD_W+1)'(-diff) : (COORD_W+1)'(diff);
      mag_in  = mag_abs[MAG_W-1:0];
      // take the shorter way around the circle
      if (IS_ANGLE && (mag_in > PI_Q13)) begin
         mag_in = (mag_in > TWO_PI_Q13) ? (mag_in - TWO_PI_Q13) : (TWO_PI_Q13 - mag_in);
      end
      // (sq * coef) >> 16 with sq split at bit 24
      wide    = {1'b0, phi_ff, (MAG_W-COEF_FRAC)'(0)}
              + WIDE_W'(plo_ff[SQ_W-1:COEF_FRAC]);
      term_in = (wide > WIDE_W'(TERM_CAP)) ? TERM_CAP : wide[TERM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prev_ff <= cur_ff;
         cur_ff  <= coord;
      end
      mag_ff  <= mag_in;
      sq_ff   <= SQ_W'(mag_ff) * SQ_W'(mag_ff);
      plo_ff  <= SQ_W'(sq_ff[MAG_W-1:0]) * SQ_W'(coef);
      sqhi_ff <= sq_ff[SQ_W-1:MAG_W];
      phi_ff  <= SQ_W'(sqhi_ff) * SQ_W'(coef);
      term_ff <= term_in;
   end

   assign term = term_ff;

endmodule

FILE: src/wpl_merge.sv
// Registered adder tree that merges the lane terms into one radicand.
`timescale 1ns / 1ps
module wpl_merge
   import wpl_pkg::*;
#(
   parameter int NUM_LANES = 6
) (
   input  logic                                clock,
   input  logic [NUM_LANES-1:0][TERM_W-1:0]    terms,
   output radicand_type                        radicand
);

   localparam int NUM_PAIRS = (NUM_LANES + 1) / 2;

   logic [2*NUM_PAIRS-1:0][TERM_W-1:0] padded;
   logic [NUM_PAIRS-1:0][TERM_W:0]     pair_in;
   logic [NUM_PAIRS-1:0][TERM_W:0]     pair_ff;
   logic [SUM_W-1:0]                   total;
   radicand_type                       rad_in;
   radicand_type                       rad_ff;

   always_comb begin
      padded                 = '0;
      padded[NUM_LANES-1:0]  = terms;
      for (int p = 0; p < NUM_PAIRS; p++) begin
         pair_in[p] = (TERM_W+1)'(padded[2*p]) + (TERM_W+1)'(padded[2*p+1]);
      end
      total = '0;
      for (int p = 0; p < NUM_PAIRS; p++) begin
         total = total + SUM_W'(pair_ff[p]);
      end
      rad_in.sat   = |total[SUM_W-1:RAD_W];
      rad_in.value = total[RAD_W-1:0];
   end

   always_ff @(posedge clock) begin
      pair_ff <= pair_in;
      rad_ff  <= rad_in;
   end

   assign radicand = rad_ff;

endmodule

FILE: src/wpl_sqrt.sv
// Iterative integer square root, two root bits per cycle.
`timescale 1ns / 1ps
module wpl_sqrt
   import wpl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  radicand_type      radicand,
   output logic              done,
   output logic [ROOT_W-1:0] root
);

   localparam int STEPS  = ROOT_W / 2;
   localparam int ITER_W = $clog2(STEPS);
   localparam int REM_W  = ROOT_W + 1;

   function automatic logic [REM_W+ROOT_W-1:0] root_step(
      input logic [REM_W-1:0]  rem,
      input logic [ROOT_W-1:0] q,
      input logic [1:0]        bits
   );
      logic [REM_W+1:0] shifted;
      logic [REM_W+1:0] trial;
      logic [REM_W+1:0] left;
      logic [REM_W-1:0] rem_out;
      logic [ROOT_W-1:0] q_out;
      shifted = {rem, bits};
      trial   = (REM_W+2)'({q, 2'b01});
      left    = shifted - trial;
      if (shifted >= trial) begin
         rem_out = left[REM_W-1:0];
         q_out   = {q[ROOT_W-2:0], 1'b1};
      end else begin
         rem_out = shifted[REM_W-1:0];
         q_out   = {q[ROOT_W-2:0], 1'b0};
      end
      return {rem_out, q_out};
   endfunction

   logic                    busy_ff;
   logic                    done_ff;
   logic [ITER_W-1:0]       iter_ff;
   logic [REM_W-1:0]        rem_ff;
   logic [ROOT_W-1:0]       q_ff;
   logic [RAD_W-1:0]        op_ff;
   logic                    sat_ff;
   logic [REM_W+ROOT_W-1:0] step_a;
   logic [REM_W+ROOT_W-1:0] step_b;

   always_comb begin
      step_a = root_step(rem_ff, q_ff, op_ff[RAD_W-1:RAD_W-2]);
      step_b = root_step(step_a[REM_W+ROOT_W-1:ROOT_W], step_a[ROOT_W-1:0],
                         op_ff[RAD_W-3:RAD_W-4]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            iter_ff <= '0;
         end else if (busy_ff) begin
            iter_ff <= iter_ff + 1'b1;
            if (iter_ff == ITER_W'(STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         q_ff   <= '0;
         op_ff  <= radicand.value;
         sat_ff <= radicand.sat;
      end else if (busy_ff) begin
         rem_ff <= step_b[REM_W+ROOT_W-1:ROOT_W];
         q_ff   <= step_b[ROOT_W-1:0];
         op_ff  <= {op_ff[RAD_W-5:0], 4'b0000};
      end
   end

   // a root of 2^24 saturates
   assign root = sat_ff ? '1 : q_ff;
   assign done = done_ff;

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("root unit restarted while busy");

   a_done_at_end: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> done_ff)
      else $error("root unit went idle without done");

   a_done_after_steps: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(iter_ff) == ITER_W'(STEPS - 1))
      else $error("root unit finished after wrong step count");

endmodule

FILE: src/weighted_path_length.sv
// Top level of the weighted path length block.
`timescale 1ns / 1ps
// Usage:
//   Points of a path enter on the req_ channel (valid/ready), one transaction
//   per point with two linear and four angular Q10.13 coordinates. Each point
//   gives exactly one rsp_ transaction: the weighted segment length from the
//   previous point and the saturating running path length, plus path_end.
//   Coefficients are written on the csr_ port while the block is idle; an
//   index beyond the coefficient list is dropped.
// Pipeline:
//   A point that starts a path (first_point, or no previous point) skips the
//   root and yields a zero result. Any other point passes through
//   5 lane stages (difference, square, two 24x24 partial products, clamp),
//   2 merge-tree stages, the loading of the root unit, the two-bit-per-cycle
//   square root and the hand-off of the result.
//   One point is in flight at a time; the next is taken once its result is handed off.
// Reset:
//   Coefficients return to 1.0, the running total clears and the next point
//   starts a new path.
// Stall:
//   A finished result waits in the output register; the block still takes the
//   next point, and holds its own result back until the register is free.
module weighted_path_length
   import wpl_pkg::*;
#(
   parameter int NUM_DIMS    = 6,
   parameter int LINEAR_DIMS = 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_first_point,
   input  logic                      req_last_point,
   input  logic signed [COORD_W-1:0] req_pos_0,
   input  logic signed [COORD_W-1:0] req_pos_1,
   input  logic signed [COORD_W-1:0] req_angle_2,
   input  logic signed [COORD_W-1:0] req_angle_3,
   input  logic signed [COORD_W-1:0] req_angle_4,
   input  logic signed [COORD_W-1:0] req_angle_5,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [ROOT_W-1:0]         rsp_segment_length,
   output logic [TOTAL_W-1:0]        rsp_path_length,
   output logic                      rsp_path_end,
   input  logic                      csr_wr_en,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [COEF_W-1:0]         csr_wdata
);

   // dimensions past the sixth get no lane and never add to the sum
   localparam int NUM_LANES = (NUM_DIMS < CSR_COUNT) ? NUM_DIMS : CSR_COUNT;
   localparam int SETTLE    = LANE_DEPTH + MERGE_DEPTH;
   localparam int CNT_W     = $clog2(SETTLE + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_WORK,
      S_ROOT,
      S_DONE
   } state_type;

   state_type                  state_ff;
   logic [CNT_W-1:0]           cnt_ff;
   logic                       have_prev_ff;
   logic                       skip_ff;
   logic                       last_ff;
   logic [TOTAL_W-1:0]         total_ff;
   logic                       rsp_valid_ff;
   logic [ROOT_W-1:0]          rsp_seg_ff;
   logic [TOTAL_W-1:0]         rsp_path_ff;
   logic                       rsp_end_ff;
   logic [COEF_W-1:0]          coef_ff [CSR_COUNT];

   logic signed [COORD_W-1:0]  coords [CSR_COUNT];
   logic [NUM_LANES-1:0][TERM_W-1:0] terms;
   radicand_type               radicand;
   logic                       accept;
   logic                       out_free;
   logic                       sqrt_start;
   logic                       sqrt_done;
   logic [ROOT_W-1:0]          sqrt_root;
   logic [TOTAL_W:0]           sum_wide;
   logic [TOTAL_W-1:0]         total_sat;

   assign coords[0] = req_pos_0;
   assign coords[1] = req_pos_1;
   assign coords[2] = req_angle_2;
   assign coords[3] = req_angle_3;
   assign coords[4] = req_angle_4;
   assign coords[5] = req_angle_5;

   // coefficient registers, to be written only while idle; the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CSR_COUNT; i++) begin
            coef_ff[i] <= COEF_ONE;
         end
      end else if (csr_wr_en && (csr_index < CSR_IDX_W'(CSR_COUNT))) begin
         coef_ff[csr_index] <= csr_wdata;
      end
   end

   // one lane per dimension up to the sixth; lanes from LINEAR_DIMS on wrap around 2pi
   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      wpl_lane #(
         .IS_ANGLE (g >= LINEAR_DIMS)
      ) u_lane (
         .clock (clock),
         .load  (accept),
         .coord (coords[g]),
         .coef  (coef_ff[g]),
         .term  (terms[g])
      );
   end

   wpl_merge #(
      .NUM_LANES (NUM_LANES)
   ) u_merge (
      .clock    (clock),
      .terms    (terms),
      .radicand (radicand)
   );

   wpl_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (radicand),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   assign req_ready  = (state_ff == S_IDLE);
   assign accept     = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   // lanes and merge tree are free running; start the root once they settle
   assign sqrt_start = (state_ff == S_WORK) && (cnt_ff == CNT_W'(SETTLE));

   // running total saturates at the top of its range
   assign sum_wide  = (TOTAL_W+1)'(total_ff) + (TOTAL_W+1)'(sqrt_root);
   assign total_sat = sum_wide[TOTAL_W] ? '1 : sum_wide[TOTAL_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         have_prev_ff <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drop valid once taken; a result loaded in the same cycle keeps it high
         if (rsp_valid_ff && rsp_ready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  skip_ff  <= req_first_point || !have_prev_ff;
                  last_ff  <= req_last_point;
                  cnt_ff   <= '0;
                  state_ff <= (req_first_point || !have_prev_ff) ? S_DONE : S_WORK;
               end
            end
            S_WORK: begin
               if (cnt_ff == CNT_W'(SETTLE)) begin
                  state_ff <= S_ROOT;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            S_ROOT: begin
               if (sqrt_done) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               // hold the result until the output register frees up
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_seg_ff   <= skip_ff ? '0 : sqrt_root;
                  rsp_path_ff  <= skip_ff ? '0 : total_sat;
                  total_ff     <= skip_ff ? '0 : total_sat;
                  rsp_end_ff   <= last_ff;
                  have_prev_ff <= !last_ff;
                  state_ff     <= S_IDLE;
               end
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_segment_length = rsp_seg_ff;
   assign rsp_path_length    = rsp_path_ff;
   assign rsp_path_end       = rsp_end_ff;

   a_path_covers_segment: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_path_ff >= TOTAL_W'(rsp_seg_ff))
      else $error("path length below segment length");

   a_path_start_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) && out_free && skip_ff
      |=> (rsp_seg_ff == '0) && (rsp_path_ff == '0))
      else $error("path start gave nonzero length");

   a_root_done_in_flight: assert property (@(posedge clock) disable iff (reset)
      sqrt_done |-> (state_ff == S_ROOT))
      else $error("root finished with no point in flight");

endmodule
